FILE: rtl/bfc_pkg.sv
// shared types and constants for the bearing formation controller
`default_nettype none
package bfc_pkg;

  localparam int IDX_W  = 3;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 4;
  localparam int Z_W    = 17;
  localparam int N2_W   = 33;
  localparam int ROOT_W = 17;
  localparam int C_W    = 34;
  localparam int DEN_W  = 50;
  localparam int PROD_W = 51;
  localparam int DVD_W  = 57;
  localparam int SUM_W  = 32;
  localparam int OUT_W  = 24;

  localparam logic [2:0] REG_ACCEL_MODE   = 3'd0;
  localparam logic [2:0] REG_SHAPE_GAIN   = 3'd1;
  localparam logic [2:0] REG_DAMPING_GAIN = 3'd2;
  localparam logic [2:0] REG_AGENT_COUNT  = 3'd3;
  localparam logic [2:0] REG_EDGE_COUNT   = 3'd4;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_AGENT = 1'b1;

  typedef struct packed {
    logic                    command;
    logic                    run;
    logic [IDX_W-1:0]        slot;
    logic [IDX_W-1:0]        plus_agent;
    logic [IDX_W-1:0]        minus_agent;
    logic signed [VAL_W-1:0] bearing_x;
    logic signed [VAL_W-1:0] bearing_y;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
  } cmd_t;

  typedef struct packed {
    logic             accel_mode;
    logic [15:0]      shape_gain;
    logic [15:0]      damping_gain;
    logic [CNT_W-1:0] agents;
    logic [CNT_W-1:0] edges;
  } cfg_t;

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_EDGE = 15'b000000000000010,
    ST_DIFF = 15'b000000000000100,
    ST_SQ   = 15'b000000000001000,
    ST_NORM = 15'b000000000010000,
    ST_ROOT = 15'b000000000100000,
    ST_DEN  = 15'b000000001000000,
    ST_NUMX = 15'b000000010000000,
    ST_DIVX = 15'b000000100000000,
    ST_NUMY = 15'b000001000000000,
    ST_DIVY = 15'b000010000000000,
    ST_ADDP = 15'b000100000000000,
    ST_ADDM = 15'b001000000000000,
    ST_OMUL = 15'b010000000000000,
    ST_OUT  = 15'b100000000000000
  } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/bfc_front.sv
// input decode and two-entry command queue
`default_nettype none
module bfc_front #(
  parameter int AGENT_DEPTH = 8,
  parameter int EDGE_DEPTH  = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [111:0]               s_axis_tdata,
  input  wire logic                       s_axis_tuser,
  input  wire logic [bfc_pkg::CNT_W-1:0]  agents,
  output logic                            cmd_valid,
  input  wire logic                       cmd_ready,
  output bfc_pkg::cmd_t                   cmd
);
  import bfc_pkg::*;

  cmd_t       dec;
  logic       drop;
  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  always_comb begin
    dec.command     = s_axis_tuser;
    dec.slot        = s_axis_tdata[2:0];
    dec.plus_agent  = s_axis_tdata[5:3];
    dec.minus_agent = s_axis_tdata[8:6];
    dec.bearing_x   = s_axis_tdata[24:9];
    dec.bearing_y   = s_axis_tdata[40:25];
    dec.pos_x       = s_axis_tdata[56:41];
    dec.pos_y       = s_axis_tdata[72:57];
    dec.vel_x       = s_axis_tdata[88:73];
    dec.vel_y       = s_axis_tdata[104:89];
    dec.run         = (s_axis_tuser == CMD_AGENT) &&
                      ({1'b0, s_axis_tdata[2:0]} + 4'd1 == agents);
    if (s_axis_tuser == CMD_AGENT) begin
      drop = {1'b0, s_axis_tdata[2:0]} >= 4'(AGENT_DEPTH);
    end else begin
      drop = {1'b0, s_axis_tdata[2:0]} >= 4'(EDGE_DEPTH);
    end
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready && !drop;
  assign cmd_valid     = (count != 2'd0);
  assign pop           = cmd_valid && cmd_ready;
  assign cmd           = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bfc_sqrt.sv
// iterative integer square root, two radicand bits per cycle
`default_nettype none
module bfc_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bfc_pkg::N2_W-1:0]    radicand,
  output logic                             done,
  output logic [bfc_pkg::ROOT_W-1:0]       root
);
  import bfc_pkg::*;

  logic [N2_W:0] rem;
  logic [N2_W:0] res;
  logic [N2_W:0] bitpos;
  logic          busy;
  logic [N2_W:0] trial;

  assign trial = res + bitpos;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        rem    <= {1'b0, radicand};
        res    <= '0;
        bitpos <= (N2_W+1)'(1) << (N2_W - 1);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitpos;
        end else begin
          res <= res >> 1;
        end
        bitpos <= bitpos >> 2;
        if (bitpos[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bfc_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module bfc_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bfc_pkg::DVD_W-1:0]  dividend,
  input  wire logic [bfc_pkg::DEN_W-1:0]  divisor,
  output logic                            done,
  output logic [bfc_pkg::DVD_W-1:0]       quotient
);
  import bfc_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [5:0]       steps;
  logic             busy;
  logic             fits;

  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        quotient <= dividend;
        steps    <= 6'(DVD_W - 1);
      end else if (busy) begin
        if (fits) begin
          rem <= DEN_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[DEN_W-1:0];
        end
        quotient <= {quotient[DVD_W-2:0], fits};
        steps    <= steps - 6'd1;
        if (steps == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bfc_back.sv
// stores, edge walk sequencer and result stage
`default_nettype none
module bfc_back #(
  parameter int AGENT_DEPTH = 8,
  parameter int EDGE_DEPTH  = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bfc_pkg::cfg_t  cfg,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire bfc_pkg::cmd_t  cmd,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [55:0]         m_axis_tdata,
  output logic                m_axis_tlast
);
  import bfc_pkg::*;

  localparam int AW = $clog2(AGENT_DEPTH);
  localparam int EW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;

  back_state_t state;

  logic [IDX_W-1:0]        end_p  [EDGE_DEPTH];
  logic [IDX_W-1:0]        end_m  [EDGE_DEPTH];
  logic signed [VAL_W-1:0] brg_x  [EDGE_DEPTH];
  logic signed [VAL_W-1:0] brg_y  [EDGE_DEPTH];
  logic signed [VAL_W-1:0] pos_x  [AGENT_DEPTH];
  logic signed [VAL_W-1:0] pos_y  [AGENT_DEPTH];
  logic signed [VAL_W-1:0] vel_x  [AGENT_DEPTH];
  logic signed [VAL_W-1:0] vel_y  [AGENT_DEPTH];
  logic signed [SUM_W-1:0] sum_x  [AGENT_DEPTH];
  logic signed [SUM_W-1:0] sum_y  [AGENT_DEPTH];
  logic [AGENT_DEPTH-1:0]  degen;

  logic [CNT_W-1:0]        e;
  logic [CNT_W-1:0]        a;
  logic [IDX_W-1:0]        p;
  logic [IDX_W-1:0]        m;
  logic signed [VAL_W-1:0] bx;
  logic signed [VAL_W-1:0] by;
  logic signed [VAL_W-1:0] px;
  logic signed [VAL_W-1:0] py;
  logic signed [Z_W-1:0]   zx;
  logic signed [Z_W-1:0]   zy;
  logic [N2_W-1:0]         sqx;
  logic [N2_W-1:0]         sqy;
  logic signed [C_W-1:0]   zybx;
  logic signed [C_W-1:0]   zxby;
  logic [N2_W-1:0]         n2;
  logic signed [C_W-1:0]   c;
  logic [ROOT_W-1:0]       n;
  logic [DEN_W-1:0]        den;
  logic [PROD_W-1:0]       mag;
  logic                    neg;
  logic                    div_go;
  logic signed [SUM_W-1:0] wx;
  logic signed [SUM_W-1:0] wy;
  logic signed [47:0]      gx;
  logic signed [47:0]      gy;
  logic signed [31:0]      dx;
  logic signed [31:0]      dy;

  logic [IDX_W-1:0]        ep;
  logic [IDX_W-1:0]        em;
  logic [IDX_W-1:0]        pa;
  logic [IDX_W-1:0]        sa;
  logic [N2_W-1:0]         n2_sum;
  logic signed [PROD_W-1:0] prod;
  logic [DVD_W-1:0]        dividend;
  logic                    sqrt_done;
  logic [ROOT_W-1:0]       sqrt_root;
  logic                    div_done;
  logic [DVD_W-1:0]        div_q;
  logic signed [SUM_W-1:0] w_new;
  logic signed [OUT_W-1:0] res_x;
  logic signed [OUT_W-1:0] res_y;
  logic                    out_free;

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [47:0] g,
                                                     input logic signed [31:0] d,
                                                     input logic accel);
    logic signed [49:0] t;
    logic signed [37:0] q;
    t = 50'(g) + 50'sd2048;
    if (accel) t = t - (50'(d) <<< 4);
    q = 38'(t >>> 12);
    if (q > 38'sd8388607) return 24'sh7fffff;
    else if (q < -38'sd8388608) return 24'sh800000;
    else return q[OUT_W-1:0];
  endfunction

  assign ep        = end_p[e[EW-1:0]];
  assign em        = end_m[e[EW-1:0]];
  assign pa        = (state == ST_EDGE) ? ep : m;
  assign sa        = (state == ST_ADDP) ? p : ((state == ST_ADDM) ? m : a[IDX_W-1:0]);
  assign n2_sum    = sqx + sqy;
  assign cmd_ready = (state == ST_IDLE);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign dividend  = DVD_W'({mag, 6'd0}) + DVD_W'(den >> 1);
  assign w_new     = neg ? -SUM_W'(div_q) : SUM_W'(div_q);
  assign res_x     = finish(gx, dx, cfg.accel_mode);
  assign res_y     = finish(gy, dy, cfg.accel_mode);

  always_comb begin
    if (state == ST_NUMX) prod = PROD_W'(-zy) * PROD_W'(c);
    else prod = PROD_W'(zx) * PROD_W'(c);
  end

  bfc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == ST_NORM) && (n2_sum != '0)),
    .radicand (n2_sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  bfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      if (cmd.command == CMD_EDGE) begin
        end_p[cmd.slot[EW-1:0]] <= cmd.plus_agent;
        end_m[cmd.slot[EW-1:0]] <= cmd.minus_agent;
        brg_x[cmd.slot[EW-1:0]] <= cmd.bearing_x;
        brg_y[cmd.slot[EW-1:0]] <= cmd.bearing_y;
      end else begin
        pos_x[cmd.slot[AW-1:0]] <= cmd.pos_x;
        pos_y[cmd.slot[AW-1:0]] <= cmd.pos_y;
        vel_x[cmd.slot[AW-1:0]] <= cmd.vel_x;
        vel_y[cmd.slot[AW-1:0]] <= cmd.vel_y;
      end
    end
    if (cmd_valid && cmd_ready && cmd.run) begin
      for (int i = 0; i < AGENT_DEPTH; i++) begin
        sum_x[i] <= '0;
        sum_y[i] <= '0;
      end
    end else if (state == ST_ADDP) begin
      sum_x[sa[AW-1:0]] <= sum_x[sa[AW-1:0]] + wx;
      sum_y[sa[AW-1:0]] <= sum_y[sa[AW-1:0]] + wy;
    end else if (state == ST_ADDM) begin
      sum_x[sa[AW-1:0]] <= sum_x[sa[AW-1:0]] - wx;
      sum_y[sa[AW-1:0]] <= sum_y[sa[AW-1:0]] - wy;
    end
    if (state == ST_EDGE) begin
      p  <= ep;
      m  <= em;
      bx <= brg_x[e[EW-1:0]];
      by <= brg_y[e[EW-1:0]];
      px <= pos_x[pa[AW-1:0]];
      py <= pos_y[pa[AW-1:0]];
    end
    if (state == ST_DIFF) begin
      zx <= Z_W'(px) - Z_W'(pos_x[pa[AW-1:0]]);
      zy <= Z_W'(py) - Z_W'(pos_y[pa[AW-1:0]]);
    end
    if (state == ST_SQ) begin
      sqx  <= N2_W'(zx * zx);
      sqy  <= N2_W'(zy * zy);
      zybx <= C_W'(zy) * C_W'(bx);
      zxby <= C_W'(zx) * C_W'(by);
    end
    if (state == ST_NORM) begin
      n2 <= n2_sum;
      c  <= zxby - zybx;
    end
    if (sqrt_done) n <= sqrt_root;
    if (state == ST_DEN) den <= DEN_W'(n2) * DEN_W'(n);
    if (state == ST_NUMX || state == ST_NUMY) begin
      neg <= prod[PROD_W-1];
      mag <= prod[PROD_W-1] ? -prod : prod;
    end
    if (state == ST_DIVX && div_done) wx <= w_new;
    if (state == ST_DIVY && div_done) wy <= w_new;
    if (state == ST_OMUL) begin
      gx <= $signed({1'b0, cfg.shape_gain}) * 48'(sum_x[sa[AW-1:0]]);
      gy <= $signed({1'b0, cfg.shape_gain}) * 48'(sum_y[sa[AW-1:0]]);
      dx <= $signed({1'b0, cfg.damping_gain}) * 32'(vel_x[sa[AW-1:0]]);
      dy <= $signed({1'b0, cfg.damping_gain}) * 32'(vel_y[sa[AW-1:0]]);
    end
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= {4'd0, degen[sa[AW-1:0]], res_y, res_x, sa};
      m_axis_tlast <= (a + 4'd1 == cfg.agents);
    end
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      div_go        <= 1'b0;
      degen         <= '0;
      e             <= '0;
      a             <= '0;
    end else begin
      div_go <= (state == ST_NUMX) || (state == ST_NUMY);
      if (state == ST_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd.run) begin
            degen <= '0;
            e     <= '0;
            state <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          if (e == cfg.edges) begin
            a     <= '0;
            state <= ST_OMUL;
          end else if ({1'b0, ep} >= cfg.agents || {1'b0, em} >= cfg.agents) begin
            e <= e + 4'd1;
          end else begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: state <= ST_SQ;
        ST_SQ:   state <= ST_NORM;
        ST_NORM: begin
          if (n2_sum == '0) begin
            degen <= degen | (AGENT_DEPTH'(1) << p[AW-1:0])
                           | (AGENT_DEPTH'(1) << m[AW-1:0]);
            e     <= e + 4'd1;
            state <= ST_EDGE;
          end else begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: if (sqrt_done) state <= ST_DEN;
        ST_DEN:  state <= ST_NUMX;
        ST_NUMX: state <= ST_DIVX;
        ST_DIVX: if (div_done) state <= ST_NUMY;
        ST_NUMY: state <= ST_DIVY;
        ST_DIVY: if (div_done) state <= ST_ADDP;
        ST_ADDP: state <= ST_ADDM;
        ST_ADDM: begin
          e     <= e + 4'd1;
          state <= ST_EDGE;
        end
        ST_OMUL: state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            a     <= a + 4'd1;
            state <= (a + 4'd1 == cfg.agents) ? ST_IDLE : ST_OMUL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bearing_formation_control.sv
// bearing formation controller top level: config registers, front and back
// edge and agent beats are stored by the back sequencer while it is idle; a front
// queue of two entries takes beats while the back is busy
// the last agent beat starts an edge walk that runs the bit-serial square root
// and two divides for each valid, non-degenerate edge in use, then emits one
// result beat per agent
// synchronous reset clears control state and config to defaults; no store clearing
`default_nettype none
module bearing_formation_control #(
  parameter int MAX_AGENTS = 8,
  parameter int MAX_EDGES  = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,   // slot, plus_agent, minus_agent, bearing_x,
                                            // bearing_y, pos_x, pos_y, vel_x, vel_y
  input  wire logic         s_axis_tuser,   // command
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [55:0]       m_axis_tdata,   // agent, ctrl_x, ctrl_y, degenerate
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import bfc_pkg::*;

  localparam int AGENT_DEPTH = (MAX_AGENTS < 8) ? MAX_AGENTS : 8;
  localparam int EDGE_DEPTH  = (MAX_EDGES < 8) ? MAX_EDGES : 8;

  logic        accel_mode;
  logic [15:0] shape_gain;
  logic [15:0] damping_gain;
  logic [3:0]  agent_count;
  logic [3:0]  edge_count;
  cfg_t        cfg;
  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_mode   <= 1'b1;
      shape_gain   <= 16'd4096;
      damping_gain <= 16'd4096;
      agent_count  <= 4'd8;
      edge_count   <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACCEL_MODE:   accel_mode   <= cfg_data[0];
        REG_SHAPE_GAIN:   shape_gain   <= cfg_data;
        REG_DAMPING_GAIN: damping_gain <= cfg_data;
        REG_AGENT_COUNT:  agent_count  <= cfg_data[3:0];
        REG_EDGE_COUNT:   edge_count   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.accel_mode   = accel_mode;
    cfg.shape_gain   = shape_gain;
    cfg.damping_gain = damping_gain;
    if (agent_count == 4'd0) cfg.agents = 4'd1;
    else if (agent_count > 4'(AGENT_DEPTH)) cfg.agents = 4'(AGENT_DEPTH);
    else cfg.agents = agent_count;
    if (edge_count > 4'(EDGE_DEPTH)) cfg.edges = 4'(EDGE_DEPTH);
    else cfg.edges = edge_count;
  end

  bfc_front #(
    .AGENT_DEPTH (AGENT_DEPTH),
    .EDGE_DEPTH  (EDGE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .agents        (cfg.agents),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  bfc_back #(
    .AGENT_DEPTH (AGENT_DEPTH),
    .EDGE_DEPTH  (EDGE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_last_agent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> {1'b0, m_axis_tdata[2:0]} + 4'd1 == cfg.agents)
    else $error("last beat not on final agent");
  a_inner_agent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> {1'b0, m_axis_tdata[2:0]} + 4'd1 < cfg.agents)
    else $error("result beat beyond agent count");
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[55:52] == 4'd0)
    else $error("result padding not zero");
`endif

endmodule
`default_nettype wire
